// ===== hdl/bats_pkg.sv =====
// Shared types, glyph table and symbol lookup for the block-average-to-symbol unit.
`default_nettype none

package bats_pkg;

	localparam int SUM_W    = 12;
	localparam int ACC_W    = 10;
	localparam int SYM_W    = 6;
	localparam int GLYPHS_N = 11;
	localparam int SUM_STEP = 216;

	// Brightness ramp, darkest first: . : ; 7 2 5 4 6 9 0 8
	localparam logic [SYM_W-1:0] GLYPHS [GLYPHS_N] = '{
		6'd46, 6'd58, 6'd59, 6'd55, 6'd50, 6'd53, 6'd52, 6'd54, 6'd57, 6'd48, 6'd56
	};

	typedef struct packed {
		logic [SYM_W-1:0] symbol_code;
		logic             row_end;
		logic             frame_end;
	} result_t;

	// floor(sum / 216), saturated at the last glyph, then looked up.
	function automatic logic [SYM_W-1:0] glyph_of(input logic [SUM_W-1:0] sum);
		logic [3:0] idx;
		idx = '0;
		for (int k = 1; k < GLYPHS_N; k++) begin
			if (sum >= SUM_W'(k * SUM_STEP))
				idx = 4'(k);
		end
		return GLYPHS[idx];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/bats_skid.sv =====
// Two-entry output buffer: result register plus skid slot.
`default_nettype none

module bats_skid
	import bats_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output result_t      m_data,
	output logic [1:0]   occ
);

	logic    skid_valid_q;
	result_t skid_q;
	result_t out_q;

	assign m_tvalid = (occ != 2'd0);
	assign m_data   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ          <= 2'd0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!m_tvalid || m_tready) begin
				if (skid_valid_q) begin
					skid_valid_q <= push;
					occ          <= push ? 2'd2 : 2'd1;
				end else begin
					occ <= push ? 2'd1 : 2'd0;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
				occ          <= 2'd2;
			end
		end
	end

	// Payload: refill the head from the skid slot first, park a push when the head holds.
	always_ff @(posedge clk) begin
		if (!m_tvalid || m_tready) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/block_average_to_symbol_unit.sv =====
// Top level: 3x3 box average of a gray raster stream, mapped to ASCII symbols.
//
//  channel  | dir | transaction                 | payload
//  ---------+-----+-----------------------------+-----------------------------------------
//  s_*      | in  | one gray pixel, raster      | tdata[7:0] gray_pixel
//  m_*      | out | one tile symbol             | tdata[5:0] symbol_code, tlast row_end,
//           |     |                             | tuser frame_end
//  APB      | in  | register write / read       | 0x0 frame_width, 0x4 frame_height
//
// One pixel per cycle while s_tready is high. The third pixel of each tile row costs one
// read-modify-write of the tile column-sum memory: read issued with that pixel, sum folded
// and written back in the next cycle, symbol sent from a two-entry output buffer.
// Reset clears counters and the row accumulator and sets the registers to 640 x 480; the
// sum memory is not cleared, since the first row of every tile writes rather than adds.
// Hold s_tready low while both buffer slots are taken or one waits as another enters.
`default_nettype none

module block_average_to_symbol_unit
	import bats_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] gray_pixel
	// master stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [5:0] symbol_code, [7:6] zero
	output logic             m_tlast,   // row_end
	output logic             m_tuser,   // [0] frame_end
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int SUM_DEPTH = (MAX_WIDTH + 2) / 3;
	localparam int AW        = $clog2(SUM_DEPTH);
	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WCW       = $clog2(MAX_WIDTH + 1);
	localparam int CMPW      = ((WCW > 12) ? WCW : 12) + 2;
	localparam int RW        = 12;
	localparam int HW        = 14;
	localparam int HEIGHT_LIMIT = 4096;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// ---------------- configuration ----------------
	logic [11:0] frame_width_q;
	logic [12:0] frame_height_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 12'd640;
			frame_height_q <= 13'd480;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  frame_width_q  <= pwdata[11:0];
				REG_HEIGHT: frame_height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {20'd0, frame_width_q};
			REG_HEIGHT: prdata = {19'd0, frame_height_q};
			default:    prdata = '0;
		endcase
	end

	// Effective dimensions, clamped to 1..MAX_WIDTH and 1..4096.
	logic [CMPW-1:0] w_eff;
	logic [HW-1:0]   h_eff;

	always_comb begin
		w_eff = CMPW'(frame_width_q);
		if (w_eff == '0)
			w_eff = CMPW'(1);
		else if (w_eff > CMPW'(MAX_WIDTH))
			w_eff = CMPW'(MAX_WIDTH);
		h_eff = HW'(frame_height_q);
		if (h_eff == '0)
			h_eff = HW'(1);
		else if (h_eff > HW'(HEIGHT_LIMIT))
			h_eff = HW'(HEIGHT_LIMIT);
	end

	// ---------------- stage 0: raster position, row accumulator, memory read ----------------
	logic [CW-1:0]    col_q;
	logic [1:0]       col_ph_q;
	logic [AW-1:0]    tcol_q;
	logic [RW-1:0]    row_q;
	logic [1:0]       row_ph_q;
	logic [RW-1:0]    row_start_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_next;
	logic [CMPW-1:0]  col_ext;
	logic [HW-1:0]    row_ext;
	logic [HW-1:0]    rs_ext;
	logic             in_fire;
	logic             last_col;
	logic             last_row;
	logic             fold_s0;
	logic             row_end_s0;
	logic             frame_end_s0;

	assign in_fire = s_tvalid && s_tready;
	assign col_ext = CMPW'(col_q);
	assign row_ext = HW'(row_q);
	assign rs_ext  = HW'(row_start_q);

	assign last_col = (col_ext + CMPW'(1)) >= w_eff;
	assign last_row = (row_ext + HW'(1)) >= h_eff;

	// A tile exists when its start plus 3 lies below the dimension; at the third column
	// of a tile that is column + 1 < width.
	assign fold_s0      = (col_ph_q == 2'd2) && ((col_ext + CMPW'(1)) < w_eff)
	                      && ((rs_ext + HW'(3)) < h_eff);
	assign row_end_s0   = !((col_ext + CMPW'(4)) < w_eff);
	assign frame_end_s0 = row_end_s0 && !((rs_ext + HW'(6)) < h_eff);

	assign acc_next = (col_ph_q == 2'd0) ? ACC_W'(s_tdata)
	                                     : acc_q + ACC_W'(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			col_ph_q    <= 2'd0;
			tcol_q      <= '0;
			row_q       <= '0;
			row_ph_q    <= 2'd0;
			row_start_q <= '0;
			acc_q       <= '0;
		end else if (in_fire) begin
			acc_q <= acc_next;
			if (last_col) begin
				col_q    <= '0;
				col_ph_q <= 2'd0;
				tcol_q   <= '0;
				if (last_row) begin
					row_q       <= '0;
					row_ph_q    <= 2'd0;
					row_start_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
					if (row_ph_q == 2'd2) begin
						row_ph_q    <= 2'd0;
						row_start_q <= row_start_q + RW'(3);
					end else begin
						row_ph_q <= row_ph_q + 2'd1;
					end
				end
			end else begin
				col_q <= col_q + CW'(1);
				if (col_ph_q == 2'd2) begin
					col_ph_q <= 2'd0;
					tcol_q   <= tcol_q + AW'(1);
				end else begin
					col_ph_q <= col_ph_q + 2'd1;
				end
			end
		end
	end

	// ---------------- tile column-sum memory ----------------
	logic [SUM_W-1:0] sum_mem [SUM_DEPTH];
	logic [SUM_W-1:0] rd_data_s1;
	logic [SUM_W-1:0] sum_s1;
	logic             wr_en_s1;
	logic [AW-1:0]    tcol_s1;

	always_ff @(posedge clk) begin
		if (in_fire)
			rd_data_s1 <= sum_mem[tcol_q];
		if (wr_en_s1)
			sum_mem[tcol_s1] <= sum_s1;
	end

	// ---------------- stage 1: fold row sum, write back, form symbol ----------------
	logic             valid_s1;
	logic             first_s1;
	logic             last_s1;
	logic [ACC_W-1:0] acc_s1;
	logic             row_end_s1;
	logic             frame_end_s1;
	logic             push_s1;
	result_t          res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_fire && fold_s0;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_s1     <= (row_ph_q == 2'd0);
			last_s1      <= (row_ph_q == 2'd2);
			tcol_s1      <= tcol_q;
			acc_s1       <= acc_next;
			row_end_s1   <= row_end_s0;
			frame_end_s1 <= frame_end_s0;
		end
	end

	// First row of a tile overwrites, so stale entries from the previous tile row never leak.
	assign sum_s1   = first_s1 ? SUM_W'(acc_s1) : rd_data_s1 + SUM_W'(acc_s1);
	assign wr_en_s1 = valid_s1;
	assign push_s1  = valid_s1 && last_s1;

	assign res_s1.symbol_code = glyph_of(sum_s1);
	assign res_s1.row_end     = row_end_s1;
	assign res_s1.frame_end   = frame_end_s1;

	// ---------------- output buffer ----------------
	logic [1:0] occ;
	result_t    m_data;

	bats_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_s1),
		.push_data (res_s1),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_data    (m_data),
		.occ       (occ)
	);

	// Hold input only when buffered results plus the one in flight would fill both slots.
	assign s_tready = (occ == 2'd0) || ((occ == 2'd1) && !push_s1);

	assign m_tdata = {2'b00, m_data.symbol_code};
	assign m_tlast = m_data.row_end;
	assign m_tuser = m_data.frame_end;

	// ---------------- assertions ----------------
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!((occ == 2'd2) && push_s1))
		else $error("result pushed into a full output buffer");

	a_frame_end_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tuser || m_tlast))
		else $error("frame end without row end");

	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && fold_s0) |-> !valid_s1)
		else $error("back-to-back folds on the sum memory");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_ph_q != 2'd3) && (row_ph_q != 2'd3))
		else $error("tile phase counter out of range");

	a_fold_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && fold_s0) |=> wr_en_s1)
		else $error("tile fold lost before write-back");

endmodule

`default_nettype wire
